/* src/per_entry_running_stats_with_deltas_macros.svh */
// ----------------------------------------------------------------------------
// per_entry_running_stats_with_deltas_macros
// assertion shorthands, sampled on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef PER_ENTRY_RUNNING_STATS_WITH_DELTAS_MACROS_SVH
`define PER_ENTRY_RUNNING_STATS_WITH_DELTAS_MACROS_SVH

// property holds at every edge out of reset
`define PERS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition never seen at an edge out of reset
`define PERS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* src/pers_pkg.sv */
// ----------------------------------------------------------------------------
// pers_pkg
// shared types and constants of the per-entry running statistics block
// ----------------------------------------------------------------------------
package pers_pkg;

  localparam int ENTRIES   = 1024;
  localparam int ENTRY_W   = 10;
  localparam int FRAC      = 16;
  localparam int NUM_CH    = 6;
  localparam int CH_W      = 3;
  localparam int CNT_W     = 5;
  localparam int TIME_W    = 32;
  localparam int FRM_W     = 32;
  localparam int VAL_W     = 48;
  localparam int M2_W      = 64;
  localparam int DIV_W     = 32;
  localparam int DELTA_W   = CNT_W + 1;
  localparam int CH_ADDR_W = ENTRY_W + CH_W;
  localparam int CH_DEPTH  = 1 << CH_ADDR_W;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  localparam logic [CH_W-1:0] CH_COUNT = 3'd0;
  localparam logic [CH_W-1:0] CH_OCC   = 3'd1;
  localparam logic [CH_W-1:0] CH_DELTA = 3'd2;
  localparam logic [CH_W-1:0] CH_ABS   = 3'd3;
  localparam logic [CH_W-1:0] CH_SQ    = 3'd4;
  localparam logic [CH_W-1:0] CH_RATE  = 3'd5;

  typedef struct packed {
    logic              valid;
    logic [CNT_W-1:0]  prev_count;
    logic [TIME_W-1:0] prev_time;
    logic [FRM_W-1:0]  frames;
    logic [FRM_W-1:0]  deltas;
  } entry_rec_t;

  typedef struct packed {
    logic [VAL_W-1:0] mean;
    logic [M2_W-1:0]  m2;
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
    logic [FRM_W-1:0] lo_frame;
    logic [FRM_W-1:0] hi_frame;
  } chan_rec_t;

  localparam int ENTRY_REC_W = $bits(entry_rec_t);
  localparam int CHAN_REC_W  = $bits(chan_rec_t);

  typedef struct packed {
    logic                 clr;
    logic [CH_ADDR_W-1:0] clr_addr;
    logic                 load_in;
    logic                 latch_e;
    logic                 rate_start;
    logic                 rate_latch;
    logic [CH_W-1:0]      ch;
    logic                 ch_latch;
    logic                 mean_step;
    logic                 mul_step;
    logic                 c_wr;
    logic                 e_wr;
    logic                 out_fire;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_read;
    logic delta_valid;
    logic div_done;
  } dp_sts_t;

endpackage

/* src/pers_ram.sv */
// ----------------------------------------------------------------------------
// pers_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module pers_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wr_data,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[addr] <= wr_data;
    end
    rd_data_r <= mem_r[addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* src/pers_div.sv */
// ----------------------------------------------------------------------------
// pers_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pers_div
  import pers_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DIV_W);

  logic [DIV_W:0]    rem_r, rem_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [DIV_W-1:0]  dvs_r, dvs_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [DIV_W:0]    trial;
  logic              ge;

  assign trial = {rem_r[DIV_W-1:0], quo_r[DIV_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    step_nxt = step_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      step_nxt = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      rem_nxt  = ge ? trial - {1'b0, dvs_r} : trial;
      quo_nxt  = {quo_r[DIV_W-2:0], ge};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(DIV_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* src/pers_dp.sv */
// ----------------------------------------------------------------------------
// pers_dp
// datapath: entry and channel stores, shared divider, welford update
// ----------------------------------------------------------------------------
module pers_dp
  import pers_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  ctl_cmd_t                 cmd,
  output dp_sts_t                  sts,
  input  logic                     in_command,
  input  logic [ENTRY_W-1:0]       in_entry,
  input  logic [CNT_W-1:0]         in_sample_count,
  input  logic [FRM_W-1:0]         in_frame_number,
  input  logic [TIME_W-1:0]        in_sample_time,
  input  logic [CH_W-1:0]          in_channel,
  output logic                     out_valid,
  output logic signed [VAL_W-1:0]  out_mean_value,
  output logic [M2_W-1:0]          out_sum_sq_dev,
  output logic signed [VAL_W-1:0]  out_min_value,
  output logic signed [VAL_W-1:0]  out_max_value,
  output logic [FRM_W-1:0]         out_min_frame_number,
  output logic [FRM_W-1:0]         out_max_frame_number,
  output logic [FRM_W-1:0]         out_samples_seen
);

  // latched request
  logic               cmd_r;
  logic [ENTRY_W-1:0] entry_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [FRM_W-1:0]   frame_r;
  logic [TIME_W-1:0]  time_r;
  logic [CH_W-1:0]    chsel_r;

  // per-entry working values
  logic                      valid_r;
  logic [FRM_W-1:0]          deltas_r;
  logic [FRM_W-1:0]          n_r;
  logic [FRM_W-1:0]          dn_r;
  logic signed [DELTA_W-1:0] d_r;
  logic signed [TIME_W:0]    dt_r;
  logic signed [VAL_W-1:0]   rate_r;

  // per-channel working values
  chan_rec_t               crec_r;
  logic signed [VAL_W-1:0] x_r;
  logic                    d1_neg_r;
  logic [DIV_W-1:0]        d1a_r;
  logic signed [VAL_W-1:0] mean_new_r;
  logic [DIV_W-1:0]        d2a_r;
  logic [M2_W-1:0]         prod_r;

  logic                    out_valid_r;
  chan_rec_t               out_rec_r;
  logic [FRM_W-1:0]        out_seen_r;

  entry_rec_t             e_rd, e_wdata, e_new;
  chan_rec_t              c_rd, c_wdata, c_new;
  logic [CH_ADDR_W-1:0]   c_addr;
  logic [ENTRY_W-1:0]     e_addr;
  logic [CH_W-1:0]        ch_sel;

  // ---- stores
  assign e_addr = cmd.clr ? cmd.clr_addr[ENTRY_W-1:0] : entry_r;
  assign ch_sel = (cmd_r == CMD_READ) ? chsel_r : cmd.ch;
  assign c_addr = cmd.clr ? cmd.clr_addr : {entry_r, ch_sel};
  assign e_wdata = cmd.clr ? '0 : e_new;
  assign c_wdata = cmd.clr ? '0 : c_new;

  pers_ram #(.WIDTH(ENTRY_REC_W), .DEPTH(ENTRIES)) u_entry_ram (
    .clk     (clk),
    .wr_en   (cmd.clr | cmd.e_wr),
    .addr    (e_addr),
    .wr_data (e_wdata),
    .rd_data (e_rd)
  );

  pers_ram #(.WIDTH(CHAN_REC_W), .DEPTH(CH_DEPTH)) u_chan_ram (
    .clk     (clk),
    .wr_en   (cmd.clr | cmd.c_wr),
    .addr    (c_addr),
    .wr_data (c_wdata),
    .rd_data (c_rd)
  );

  // ---- entry derived values
  logic [CNT_W-1:0]  d_abs;
  logic [2*CNT_W-1:0] d_sq;
  logic [DIV_W-1:0]  dt_abs;
  logic              rate_neg_r;

  assign d_abs  = CNT_W'(d_r[DELTA_W-1] ? -d_r : d_r);
  assign d_sq   = d_abs * d_abs;
  assign dt_abs = DIV_W'(dt_r[TIME_W] ? -dt_r : dt_r);

  // ---- channel sample
  logic signed [VAL_W-1:0] x_cur;
  always_comb begin
    unique case (cmd.ch)
      CH_COUNT: x_cur = $signed(VAL_W'(cnt_r) << FRAC);
      CH_OCC:   x_cur = (cnt_r != '0) ? $signed(VAL_W'(1) << FRAC) : '0;
      CH_DELTA: x_cur = VAL_W'(d_r) <<< FRAC;
      CH_ABS:   x_cur = $signed(VAL_W'(d_abs) << FRAC);
      CH_SQ:    x_cur = $signed(VAL_W'(d_sq) << FRAC);
      CH_RATE:  x_cur = rate_r;
      default:  x_cur = '0;
    endcase
  end

  logic signed [VAL_W:0] d1;
  assign d1 = $signed({x_cur[VAL_W-1], x_cur}) - $signed({c_rd.mean[VAL_W-1], c_rd.mean});

  // ---- shared divider
  logic [DIV_W-1:0] div_a, div_b, div_q;
  logic             div_done;
  logic [FRM_W-1:0] n_cur;

  assign n_cur = (cmd.ch == CH_COUNT || cmd.ch == CH_OCC) ? n_r : dn_r;
  assign div_a = cmd.rate_start ? DIV_W'({d_abs, {FRAC{1'b0}}}) :
                                  DIV_W'(d1[VAL_W] ? -d1 : d1);
  assign div_b = cmd.rate_start ? dt_abs : n_cur;

  pers_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.rate_start | cmd.ch_latch),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  // ---- welford arithmetic
  logic signed [VAL_W-1:0] q_s;
  logic signed [VAL_W-1:0] mean_nxt;
  logic signed [VAL_W:0]   d2;
  logic [M2_W-1:0]         prod;
  logic [M2_W:0]           m2_sum;
  logic                    first;

  assign q_s      = $signed(VAL_W'(div_q));
  assign mean_nxt = d1_neg_r ? $signed(crec_r.mean) - q_s : $signed(crec_r.mean) + q_s;
  assign d2       = $signed({x_r[VAL_W-1], x_r}) - $signed({mean_new_r[VAL_W-1], mean_new_r});
  assign prod     = d1a_r * d2a_r;
  assign m2_sum   = {1'b0, crec_r.m2} + {1'b0, prod_r >> FRAC};
  assign first    = n_cur == FRM_W'(1);

  always_comb begin
    c_new      = crec_r;
    c_new.mean = mean_new_r;
    c_new.m2   = m2_sum[M2_W] ? '1 : m2_sum[M2_W-1:0];
    if (first || x_r < $signed(crec_r.lo)) begin
      c_new.lo       = x_r;
      c_new.lo_frame = frame_r;
    end
    if (first || x_r > $signed(crec_r.hi)) begin
      c_new.hi       = x_r;
      c_new.hi_frame = frame_r;
    end
  end

  always_comb begin
    e_new.valid      = 1'b1;
    e_new.prev_count = cnt_r;
    e_new.prev_time  = time_r;
    e_new.frames     = n_r;
    e_new.deltas     = valid_r ? dn_r : deltas_r;
  end

  // ---- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.out_fire;
    end

    if (cmd.load_in) begin
      cmd_r   <= in_command;
      entry_r <= in_entry;
      cnt_r   <= in_sample_count;
      frame_r <= in_frame_number;
      time_r  <= in_sample_time;
      chsel_r <= in_channel;
    end

    if (cmd.latch_e) begin
      valid_r  <= e_rd.valid;
      deltas_r <= e_rd.deltas;
      n_r      <= (e_rd.frames == '1) ? e_rd.frames : e_rd.frames + 1'b1;
      dn_r     <= (e_rd.deltas == '1) ? e_rd.deltas : e_rd.deltas + 1'b1;
      d_r      <= $signed({1'b0, cnt_r}) - $signed({1'b0, e_rd.prev_count});
      dt_r     <= $signed({1'b0, time_r}) - $signed({1'b0, e_rd.prev_time});
    end

    if (cmd.rate_start) begin
      rate_neg_r <= d_r[DELTA_W-1] ^ dt_r[TIME_W];
    end

    if (cmd.rate_latch) begin
      if (dt_r == '0) begin
        rate_r <= '0;
      end else begin
        rate_r <= rate_neg_r ? -q_s : q_s;
      end
    end

    if (cmd.ch_latch) begin
      crec_r   <= c_rd;
      x_r      <= x_cur;
      d1_neg_r <= d1[VAL_W];
      d1a_r    <= DIV_W'(d1[VAL_W] ? -d1 : d1);
    end

    if (cmd.mean_step) begin
      mean_new_r <= mean_nxt;
    end

    if (cmd.mul_step) begin
      d2a_r <= DIV_W'(d2[VAL_W] ? -d2 : d2);
    end

    // product registered in ST_CPROD, after ST_CMUL registers the magnitude of d2
    prod_r <= prod;

    if (cmd.out_fire) begin
      if (chsel_r < CH_W'(NUM_CH)) begin
        out_rec_r  <= c_rd;
        out_seen_r <= (chsel_r == CH_COUNT || chsel_r == CH_OCC) ? e_rd.frames : e_rd.deltas;
      end else begin
        out_rec_r  <= '0;
        out_seen_r <= '0;
      end
    end
  end

  assign sts.is_read     = cmd_r == CMD_READ;
  assign sts.delta_valid = valid_r;
  assign sts.div_done    = div_done;

  assign out_valid            = out_valid_r;
  assign out_mean_value       = $signed(out_rec_r.mean);
  assign out_sum_sq_dev       = out_rec_r.m2;
  assign out_min_value        = $signed(out_rec_r.lo);
  assign out_max_value        = $signed(out_rec_r.hi);
  assign out_min_frame_number = out_rec_r.lo_frame;
  assign out_max_frame_number = out_rec_r.hi_frame;
  assign out_samples_seen     = out_seen_r;

endmodule

/* src/pers_ctrl.sv */
// ----------------------------------------------------------------------------
// pers_ctrl
// sequencer: clearing pass, read path, rate divide and channel updates
// ----------------------------------------------------------------------------
module pers_ctrl
  import pers_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd
);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_ERD   = 4'd2;
  localparam logic [3:0] ST_RLAT  = 4'd3;
  localparam logic [3:0] ST_ELAT  = 4'd4;
  localparam logic [3:0] ST_RATE  = 4'd5;
  localparam logic [3:0] ST_RATEW = 4'd6;
  localparam logic [3:0] ST_CRD   = 4'd7;
  localparam logic [3:0] ST_CLAT  = 4'd8;
  localparam logic [3:0] ST_CDIV  = 4'd9;
  localparam logic [3:0] ST_CMEAN = 4'd10;
  localparam logic [3:0] ST_CMUL  = 4'd11;
  localparam logic [3:0] ST_CWB   = 4'd12;
  localparam logic [3:0] ST_EWB   = 4'd13;
  localparam logic [3:0] ST_CPROD = 4'd14;

  logic [3:0]           state_r, state_nxt;
  logic [CH_ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [CH_W-1:0]      ch_r, ch_nxt;
  logic [CH_W-1:0]      last_ch;

  assign last_ch = sts.delta_valid ? CH_RATE : CH_OCC;

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    ch_nxt      = ch_r;
    cmd         = '0;
    cmd.clr_addr = clr_cnt_r;
    cmd.ch       = ch_r;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr     = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_ERD;
        end
      end
      ST_ERD: begin
        state_nxt = sts.is_read ? ST_RLAT : ST_ELAT;
      end
      ST_RLAT: begin
        cmd.out_fire = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_ELAT: begin
        cmd.latch_e = 1'b1;
        state_nxt   = ST_RATE;
      end
      ST_RATE: begin
        ch_nxt = CH_COUNT;
        if (sts.delta_valid) begin
          cmd.rate_start = 1'b1;
          state_nxt      = ST_RATEW;
        end else begin
          state_nxt = ST_CRD;
        end
      end
      ST_RATEW: begin
        if (sts.div_done) begin
          cmd.rate_latch = 1'b1;
          state_nxt      = ST_CRD;
        end
      end
      ST_CRD: begin
        state_nxt = ST_CLAT;
      end
      ST_CLAT: begin
        cmd.ch_latch = 1'b1;
        state_nxt    = ST_CDIV;
      end
      ST_CDIV: begin
        if (sts.div_done) begin
          state_nxt = ST_CMEAN;
        end
      end
      ST_CMEAN: begin
        cmd.mean_step = 1'b1;
        state_nxt     = ST_CMUL;
      end
      ST_CMUL: begin
        cmd.mul_step = 1'b1;
        state_nxt    = ST_CPROD;
      end
      ST_CPROD: begin
        // product of the two magnitudes is registered here
        state_nxt = ST_CWB;
      end
      ST_CWB: begin
        // m2 takes the registered product
        cmd.c_wr = 1'b1;
        if (ch_r == last_ch) begin
          state_nxt = ST_EWB;
        end else begin
          ch_nxt    = ch_r + 1'b1;
          state_nxt = ST_CRD;
        end
      end
      ST_EWB: begin
        cmd.e_wr  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      ch_r      <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      ch_r      <= ch_nxt;
    end
  end

  assign busy = state_r != ST_IDLE;

endmodule

/* src/per_entry_running_stats_with_deltas.sv */
// ----------------------------------------------------------------------------
// per_entry_running_stats_with_deltas
// welford running moments over six channels for each entry
// ----------------------------------------------------------------------------
//  channel   ports              handshake
//  input     in_*               start high, busy low at the clock edge
//  result    out_*              out_valid high for one cycle, no stall
//
//  a read word goes through the ERD and RLAT states to its result strobe;
//  busy drops with the strobe
//  an update runs one divide per channel on the single shared divider: the
//  first word of an entry updates two channels, later words first divide for
//  the rate and then update all six channels
//  after reset a clearing pass sweeps all 8192 words of the channel store
//  (and the entry store with it) while busy stays high
// ----------------------------------------------------------------------------
module per_entry_running_stats_with_deltas
  import pers_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_command,
  input  logic [ENTRY_W-1:0]      in_entry,
  input  logic [CNT_W-1:0]        in_sample_count,
  input  logic [FRM_W-1:0]        in_frame_number,
  input  logic [TIME_W-1:0]       in_sample_time,
  input  logic [CH_W-1:0]         in_channel,
  output logic                    out_valid,
  output logic signed [VAL_W-1:0] out_mean_value,
  output logic [M2_W-1:0]         out_sum_sq_dev,
  output logic signed [VAL_W-1:0] out_min_value,
  output logic signed [VAL_W-1:0] out_max_value,
  output logic [FRM_W-1:0]        out_min_frame_number,
  output logic [FRM_W-1:0]        out_max_frame_number,
  output logic [FRM_W-1:0]        out_samples_seen
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  pers_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  pers_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_command           (in_command),
    .in_entry             (in_entry),
    .in_sample_count      (in_sample_count),
    .in_frame_number      (in_frame_number),
    .in_sample_time       (in_sample_time),
    .in_channel           (in_channel),
    .out_valid            (out_valid),
    .out_mean_value       (out_mean_value),
    .out_sum_sq_dev       (out_sum_sq_dev),
    .out_min_value        (out_min_value),
    .out_max_value        (out_max_value),
    .out_min_frame_number (out_min_frame_number),
    .out_max_frame_number (out_max_frame_number),
    .out_samples_seen     (out_samples_seen)
  );

endmodule

/* src/pers_checker.sv */
// ----------------------------------------------------------------------------
// pers_checker
// port-level checks on the running statistics block
// ----------------------------------------------------------------------------
`include "per_entry_running_stats_with_deltas_macros.svh"

module pers_checker
  import pers_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    start,
  input logic                    busy,
  input logic                    in_command,
  input logic [ENTRY_W-1:0]      in_entry,
  input logic [CNT_W-1:0]        in_sample_count,
  input logic [FRM_W-1:0]        in_frame_number,
  input logic [TIME_W-1:0]       in_sample_time,
  input logic [CH_W-1:0]         in_channel,
  input logic                    out_valid,
  input logic signed [VAL_W-1:0] out_mean_value,
  input logic [M2_W-1:0]         out_sum_sq_dev,
  input logic signed [VAL_W-1:0] out_min_value,
  input logic signed [VAL_W-1:0] out_max_value,
  input logic [FRM_W-1:0]        out_min_frame_number,
  input logic [FRM_W-1:0]        out_max_frame_number,
  input logic [FRM_W-1:0]        out_samples_seen
);

  logic take;
  assign take = start && !busy;

  // a taken read word yields its result strobe
  `PERS_ASSERT(a_read_latency, (take && in_command == CMD_READ) |-> ##3 out_valid, "read result missing")
  // an update word gives no result strobe where a read would give one
  `PERS_ASSERT(a_update_silent, (take && in_command == CMD_UPDATE) |-> ##3 !out_valid, "result from update")
  // a taken word always makes the block busy
  `PERS_ASSERT(a_busy_after_take, take |=> busy, "busy not raised")
  // the strobe is a single-cycle pulse
  `PERS_NEVER(a_strobe_pulse, out_valid && $past(out_valid), "strobe longer than a cycle")

endmodule

bind per_entry_running_stats_with_deltas pers_checker u_pers_checker (.*);
